@@ design/lcfm_pkg.sv @@
// Shared constants, field widths and the store request type of the LED color fader.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package lcfm_pkg;

    localparam int LEDS_DRIVEN_DEF  = 30;
    localparam int STRIP_LENGTH_DEF = 60;
    localparam int CHANNELS         = 3;

    localparam int BYTE_INDEX_W = 7;
    localparam int BYTE_W       = 8;
    localparam int LED_INDEX_W  = 6;
    localparam int COLOR_W      = CHANNELS * BYTE_W;
    localparam int LANE_W       = 2;
    // Wide enough for the largest supported LED count (32).
    localparam int ROW_MAX_W    = 5;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef logic [CHANNELS-1:0][BYTE_W-1:0] row_t;

    typedef struct packed {
        logic                  tgt_we;
        logic [ROW_MAX_W-1:0]  tgt_row;
        logic [LANE_W-1:0]     tgt_lane;
        logic [BYTE_W-1:0]     tgt_data;
        logic                  rd_en;
        logic [ROW_MAX_W-1:0]  rd_row;
        logic                  cur_we;
        logic [ROW_MAX_W-1:0]  cur_row;
    } store_req_t;

    // floor(x/3) for any 7-bit x: x*43 >> 7 is exact below 128.
    function automatic logic [BYTE_INDEX_W-1:0] div3(input logic [BYTE_INDEX_W-1:0] x);
        logic [2*BYTE_INDEX_W-1:0] prod;
        prod = (2*BYTE_INDEX_W)'(x) * (2*BYTE_INDEX_W)'(43);
        return prod[2*BYTE_INDEX_W-1:BYTE_INDEX_W];
    endfunction

    // One smoothing step with gain 1/4: floor((3*cur + tgt) / 4).
    function automatic logic [BYTE_W-1:0] smooth(input logic [BYTE_W-1:0] cur,
                                                 input logic [BYTE_W-1:0] tgt);
        logic [BYTE_W+1:0] sum;
        sum = {cur, 1'b0} + (BYTE_W+2)'(cur) + (BYTE_W+2)'(tgt);
        return sum[BYTE_W+1:2];
    endfunction

endpackage

@@ design/lcfm_in_if.sv @@
// Command channel of the LED color fader: target byte writes and frame ticks.
// Depends on lcfm_pkg for the field widths.
`timescale 1ns / 1ps

interface lcfm_in_if;
    import lcfm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic [BYTE_INDEX_W-1:0] byte_index;
    logic [BYTE_W-1:0]       byte_value;

    modport source (output valid, mode, byte_index, byte_value, input ready);
    modport sink   (input valid, mode, byte_index, byte_value, output ready);
endinterface

@@ design/lcfm_out_if.sv @@
// Result channel of the LED color fader: one strip position and its color per transfer.
// Depends on lcfm_pkg for the field widths.
`timescale 1ns / 1ps

interface lcfm_out_if;
    import lcfm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [LED_INDEX_W-1:0] led_index;
    logic [COLOR_W-1:0]     color;
    logic                   last;

    modport source (output valid, led_index, color, last, input ready);
    modport sink   (input valid, led_index, color, last, output ready);
endinterface

@@ design/lcfm_store.sv @@
// Target and current color stores, one RGB row per LED, with a valid bit per target byte and per current row.
// Depends on lcfm_pkg; driven by the sequencer in led_color_fader_mirror_unit.
`timescale 1ns / 1ps

module lcfm_store #(
    parameter int LEDS_DRIVEN = lcfm_pkg::LEDS_DRIVEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lcfm_pkg::store_req_t req,
    output lcfm_pkg::row_t      row_next
);
    import lcfm_pkg::*;

    localparam int ROW_W = (LEDS_DRIVEN > 1) ? $clog2(LEDS_DRIVEN) : 1;

    row_t                tgt_mem [LEDS_DRIVEN];
    row_t                cur_mem [LEDS_DRIVEN];
    logic [CHANNELS-1:0] tgt_vld_reg [LEDS_DRIVEN];
    logic                cur_vld_reg [LEDS_DRIVEN];

    row_t                tgt_rd_reg;
    row_t                cur_rd_reg;
    logic [CHANNELS-1:0] tgt_rv_reg;
    logic                cur_rv_reg;

    logic [ROW_W-1:0] tgt_row;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] cur_row;

    assign tgt_row = req.tgt_row[ROW_W-1:0];
    assign rd_row  = req.rd_row[ROW_W-1:0];
    assign cur_row = req.cur_row[ROW_W-1:0];

    // Storage arrays: no reset, entries read as zero until their valid bit is set.
    always_ff @(posedge clk)
    begin
        if (req.tgt_we)
        begin
            tgt_mem[tgt_row][req.tgt_lane] <= req.tgt_data;
        end
        if (req.cur_we)
        begin
            cur_mem[cur_row] <= row_next;
        end
        if (req.rd_en)
        begin
            tgt_rd_reg <= tgt_mem[rd_row];
            cur_rd_reg <= cur_mem[rd_row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEDS_DRIVEN; i++)
            begin
                tgt_vld_reg[i] <= '0;
                cur_vld_reg[i] <= 1'b0;
            end
            tgt_rv_reg <= '0;
            cur_rv_reg <= 1'b0;
        end
        else
        begin
            if (req.tgt_we)
            begin
                tgt_vld_reg[tgt_row][req.tgt_lane] <= 1'b1;
            end
            if (req.cur_we)
            begin
                cur_vld_reg[cur_row] <= 1'b1;
            end
            if (req.rd_en)
            begin
                tgt_rv_reg <= tgt_vld_reg[rd_row];
                cur_rv_reg <= cur_vld_reg[rd_row];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            row_next[c] = smooth(cur_rv_reg ? cur_rd_reg[c] : '0,
                                 tgt_rv_reg[c] ? tgt_rd_reg[c] : '0);
        end
    end

endmodule

@@ design/led_color_fader_mirror_unit.sv @@
// Top level of the LED color fader with mirrored output: command decode, tick sequencer,
// result buffer. Depends on lcfm_pkg, lcfm_in_if, lcfm_out_if and lcfm_store.
//
//   channel  role    transfer carries
//   -------  ------  ----------------------------------------------
//   cmd      sink    mode, byte_index, byte_value
//   result   source  led_index, color, last (two per LED on a tick)
//
// For each LED a frame tick reads the row in ST_FETCH, then in ST_LOAD smooths it and
// writes it back through the single port of each store; the drain of the final result
// pair overlaps the next command.
// Reset clears the valid bits of both stores at once; no clearing pass is needed.
// A stalled result channel holds the sequencer on its read row until the buffer frees.
`timescale 1ns / 1ps

module led_color_fader_mirror_unit #(
    parameter int LEDS_DRIVEN  = lcfm_pkg::LEDS_DRIVEN_DEF,
    parameter int STRIP_LENGTH = lcfm_pkg::STRIP_LENGTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    lcfm_in_if.sink  cmd,
    lcfm_out_if.source result
);
    import lcfm_pkg::*;

    localparam int ROW_W = (LEDS_DRIVEN > 1) ? $clog2(LEDS_DRIVEN) : 1;
    localparam logic [ROW_W-1:0]        LAST_LED    = ROW_W'(LEDS_DRIVEN - 1);
    localparam logic [BYTE_INDEX_W-1:0] BYTE_LIMIT  = BYTE_INDEX_W'(LEDS_DRIVEN * CHANNELS);
    localparam logic [LED_INDEX_W-1:0]  MIRROR_BASE = LED_INDEX_W'(STRIP_LENGTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD
    } state_t;

    state_t                 state_reg,  state_next;
    logic [ROW_W-1:0]       led_reg,    led_next;
    logic                   out_vld_reg, out_vld_next;
    logic                   out_phase_reg, out_phase_next;
    logic                   out_final_reg, out_final_next;
    logic [LED_INDEX_W-1:0] out_led_reg, out_led_next;
    logic [LED_INDEX_W-1:0] out_mir_reg, out_mir_next;
    logic [COLOR_W-1:0]     out_color_reg, out_color_next;

    store_req_t             store_req;
    row_t                   row_next;

    logic                   cmd_xfer;
    logic                   res_xfer;
    logic                   buf_free;
    logic [BYTE_INDEX_W-1:0] wr_row;
    logic [LANE_W-1:0]      wr_chan;
    logic [LED_INDEX_W-1:0] led_pos;

    lcfm_store #(
        .LEDS_DRIVEN (LEDS_DRIVEN)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (store_req),
        .row_next (row_next)
    );

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign res_xfer  = result.valid && result.ready;
    // The buffer frees when empty or when its second transfer completes now.
    assign buf_free  = !out_vld_reg || (res_xfer && out_phase_reg);

    assign wr_row  = div3(cmd.byte_index);
    assign wr_chan = LANE_W'(cmd.byte_index - {wr_row[BYTE_INDEX_W-2:0], 1'b0} - wr_row);
    assign led_pos = LED_INDEX_W'(led_reg);

    assign result.valid     = out_vld_reg;
    assign result.led_index = out_phase_reg ? out_mir_reg : out_led_reg;
    assign result.color     = out_color_reg;
    assign result.last      = out_phase_reg && out_final_reg;

    always_comb
    begin
        state_next     = state_reg;
        led_next       = led_reg;
        out_vld_next   = out_vld_reg;
        out_phase_next = out_phase_reg;
        out_final_next = out_final_reg;
        out_led_next   = out_led_reg;
        out_mir_next   = out_mir_reg;
        out_color_next = out_color_reg;

        store_req          = '0;
        store_req.tgt_row  = ROW_MAX_W'(wr_row);
        // Red sits in the top byte of a row.
        store_req.tgt_lane = LANE_W'(CHANNELS - 1) - wr_chan;
        store_req.tgt_data = cmd.byte_value;
        store_req.rd_row   = ROW_MAX_W'(led_reg);
        store_req.cur_row  = ROW_MAX_W'(led_reg);

        // Drain the buffer: own index first, then the mirror.
        if (res_xfer)
        begin
            if (out_phase_reg)
            begin
                out_vld_next = 1'b0;
            end
            else
            begin
                out_phase_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    if (cmd.mode == MODE_TICK)
                    begin
                        led_next   = '0;
                        state_next = ST_FETCH;
                    end
                    else if (cmd.byte_index < BYTE_LIMIT)
                    begin
                        store_req.tgt_we = 1'b1;
                    end
                end
            end
            ST_FETCH:
            begin
                store_req.rd_en = 1'b1;
                state_next      = ST_LOAD;
            end
            ST_LOAD:
            begin
                // Hold the read row until the buffer can take the pair.
                if (buf_free)
                begin
                    store_req.cur_we = 1'b1;
                    out_vld_next     = 1'b1;
                    out_phase_next   = 1'b0;
                    out_final_next   = (led_reg == LAST_LED);
                    out_led_next     = led_pos;
                    out_mir_next     = MIRROR_BASE - led_pos;
                    out_color_next   = row_next;
                    if (led_reg == LAST_LED)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        led_next   = led_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            led_reg       <= '0;
            out_vld_reg   <= 1'b0;
            out_phase_reg <= 1'b0;
            out_final_reg <= 1'b0;
            out_led_reg   <= '0;
            out_mir_reg   <= '0;
            out_color_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            led_reg       <= led_next;
            out_vld_reg   <= out_vld_next;
            out_phase_reg <= out_phase_next;
            out_final_reg <= out_final_next;
            out_led_reg   <= out_led_next;
            out_mir_reg   <= out_mir_next;
            out_color_reg <= out_color_next;
        end
    end

`ifndef SYNTH
    a_fetch_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |=> state_reg == ST_LOAD)
        else $error("row read not followed by its load cycle");

    a_load_holds_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && !buf_free) |=> (state_reg == ST_LOAD && $stable(led_reg)))
        else $error("sequencer left a row while the result buffer was full");

    a_load_shows_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && buf_free) |=> (result.valid && !out_phase_reg))
        else $error("loaded pair did not present its own-index result first");

    a_target_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        store_req.tgt_we |-> (state_reg == ST_IDLE && !store_req.cur_we))
        else $error("target write during a frame tick");
`endif

endmodule
